[src/sha1_message_digest_unit_defines.svh]
// Assertion macros for the SHA-1 message digest unit.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

[src/sha1md_pkg.sv]
// Shared types and constants of the SHA-1 message digest unit.
// No dependencies; used by the round logic and the top level.
package sha1md_pkg;

  // The five 32-bit round variables, also used for the chaining words.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1md_work_t;

  // Initial chaining values.
  localparam sha1md_work_t InitChain = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  // Padding marker byte and block geometry.
  localparam logic [7:0] PadByte     = 8'h80;
  localparam int         NumRounds   = 80;
  localparam logic [5:0] LenStartPos = 6'd56;
  localparam logic [5:0] LastBytePos = 6'd63;

endpackage

[src/sha1md_round.sv]
// One SHA-1 compression round: the shared unit that the sequencer steps 80 times.
// Depends on sha1md_pkg for the work-variable type and round constants.
module sha1md_round (
  input  sha1md_pkg::sha1md_work_t work_i,
  input  logic [31:0]              w_i,
  input  logic [6:0]               round_i,
  output sha1md_pkg::sha1md_work_t work_o
);
  import sha1md_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  // Select the round function and constant by round group.
  always_comb begin
    if (round_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = RoundK0;
    end else if (round_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = RoundK1;
    end else if (round_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = RoundK2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = RoundK3;
    end
  end

  // Temporary sum, kept modulo 2^32.
  assign t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;

  // Rotate the variables for the next round.
  always_comb begin
    work_o.a = t;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

[src/sha1_message_digest_unit.sv]
// SHA-1 digest over a byte stream; uses sha1md_pkg and sha1md_round.
// Message bytes are taken one per cycle while the unit is idle; a byte that completes a
// 64-byte block starts a load, 80 rounds through the single round unit and a chaining add.
// A last transfer adds padding at one byte per cycle, held while a block compresses,
// and one or two blocks are compressed before the digest shows on the master side.
// Reset returns the chaining words to their initial values with a zero length.
`include "sha1_message_digest_unit_defines.svh"
module sha1_message_digest_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave side: message bytes.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] msg_byte
  input  logic         s_axis_tuser_i,   // [0] byte_valid
  input  logic         s_axis_tlast_i,
  // Master side: digest.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o    // digest_w0, digest_w1, ..., digest_w4
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_FINAL
  } state_e;

  state_e       state_q;
  state_e       ret_q;
  logic         last_blk_q;
  logic [5:0]   fill_q;
  logic [60:0]  count_q;
  logic [6:0]   round_q;
  sha1md_work_t chain_q;
  sha1md_work_t work_q;
  sha1md_work_t work_d;
  sha1md_work_t sum_d;
  logic [511:0] sched_q;
  logic [63:0]  len_q;
  logic         out_valid_q;
  logic [159:0] out_data_q;

  logic         s_accept;
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic         start_cmp;
  logic [31:0]  w_new;
  logic [31:0]  w_round;
  logic         out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Byte loading: message bytes, the marker, zero fill and the bit length.
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = s_axis_tdata_i;
    case (state_q)
      ST_IDLE: begin
        shift_en = s_accept && s_axis_tuser_i;
      end
      ST_PAD_ONE: begin
        shift_en   = 1'b1;
        shift_byte = PadByte;
      end
      ST_PAD_ZERO: begin
        shift_en   = (fill_q != LenStartPos);
        shift_byte = 8'h00;
      end
      ST_PAD_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_q[63:56];
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
    start_cmp = shift_en && (fill_q == LastBytePos);
  end

  // Message schedule: the oldest word sits in the top 32 bits of the window.
  assign w_new = sched_q[511:480] ^ sched_q[447:416] ^ sched_q[255:224] ^ sched_q[95:64];
  assign w_round = (round_q < 7'd16) ? sched_q[511:480] : {w_new[30:0], w_new[31]};

  sha1md_round u_round (
    .work_i  (work_q),
    .w_i     (w_round),
    .round_i (round_q),
    .work_o  (work_d)
  );

  // Chaining add after the last round.
  always_comb begin
    sum_d.a = chain_q.a + work_q.a;
    sum_d.b = chain_q.b + work_q.b;
    sum_d.c = chain_q.c + work_q.c;
    sum_d.d = chain_q.d + work_q.d;
    sum_d.e = chain_q.e + work_q.e;
  end

  // Sequencer, counters, chaining words and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      last_blk_q  <= 1'b0;
      fill_q      <= '0;
      count_q     <= '0;
      round_q     <= '0;
      chain_q     <= InitChain;
      out_valid_q <= 1'b0;
    end else begin
      // Output valid: set by a finished digest, cleared by a transfer.
      if ((state_q == ST_FINAL) && last_blk_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser_i) begin
              count_q <= count_q + 61'd1;
            end
            if (start_cmp) begin
              state_q    <= ST_ROUND;
              ret_q      <= s_axis_tlast_i ? ST_PAD_ONE : ST_IDLE;
              last_blk_q <= 1'b0;
              round_q    <= '0;
            end else if (s_axis_tlast_i) begin
              state_q <= ST_PAD_ONE;
            end
          end
        end
        ST_PAD_ONE: begin
          count_q <= '0;
          if (start_cmp) begin
            state_q    <= ST_ROUND;
            ret_q      <= ST_PAD_ZERO;
            last_blk_q <= 1'b0;
            round_q    <= '0;
          end else begin
            state_q <= ST_PAD_ZERO;
          end
        end
        ST_PAD_ZERO: begin
          if (!shift_en) begin
            state_q <= ST_PAD_LEN;
          end else if (start_cmp) begin
            state_q    <= ST_ROUND;
            ret_q      <= ST_PAD_ZERO;
            last_blk_q <= 1'b0;
            round_q    <= '0;
          end
        end
        ST_PAD_LEN: begin
          if (start_cmp) begin
            state_q    <= ST_ROUND;
            ret_q      <= ST_IDLE;
            last_blk_q <= 1'b1;
            round_q    <= '0;
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 7'd1;
          if (round_q == 7'(NumRounds - 1)) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!last_blk_q) begin
            chain_q <= sum_d;
            state_q <= ret_q;
          end else if (out_free) begin
            chain_q <= InitChain;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Data path: schedule window, round variables, length and digest register.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      sched_q <= {sched_q[503:0], shift_byte};
    end else if (state_q == ST_ROUND) begin
      sched_q <= {sched_q[479:0], w_round};
    end
    if (start_cmp) begin
      work_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      work_q <= work_d;
    end
    if (state_q == ST_PAD_ONE) begin
      len_q <= {count_q, 3'b000};
    end else if (state_q == ST_PAD_LEN) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if ((state_q == ST_FINAL) && last_blk_q && out_free) begin
      out_data_q <= {sum_d.e, sum_d.d, sum_d.c, sum_d.b, sum_d.a};
    end
  end

  // Checks on the sequencer.
  `SHA1MD_ASSERT_NOW(a_round_range, state_q == ST_ROUND, round_q < 7'(NumRounds), "round index out of range")
  `SHA1MD_ASSERT_NEXT(a_full_block_compresses, s_accept && s_axis_tuser_i && (fill_q == LastBytePos), state_q == ST_ROUND, "full block not compressed")
  `SHA1MD_ASSERT_NOW(a_len_position, state_q == ST_PAD_LEN, fill_q >= LenStartPos, "length bytes placed before position 56")
  `SHA1MD_ASSERT_NOW(a_chain_restart, $rose(out_valid_q), chain_q == InitChain, "chaining words not restarted after digest")

endmodule

[dv/tb.sv]
// Self-checking testbench for sha1_message_digest_unit: directed vectors, then random messages.
// Depends on sha1md_pkg for the initial chaining words, round constants and padding geometry.
module tb;
  import sha1md_pkg::*;

  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned HoldCycles    = 1000;
  localparam int unsigned TailCycles    = 300;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned MinMessages   = 40;
  localparam int unsigned MaxPrinted    = 40;
  localparam int unsigned NumDirected   = 16;

  // Digests as they travel on the master side, digest_w0 in the lowest bits.
  localparam logic [159:0] EmptyDigest =
    {32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d, 32'hda39a3ee};
  localparam logic [159:0] AbcDigest =
    {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36};

  // One directed stimulus row; the digest is only used when has_digest is set.
  typedef struct packed {
    logic [7:0]   msg_byte;
    logic         byte_valid;
    logic         last;
    logic         has_digest;
    logic [159:0] digest;
  } stim_row_t;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    // Right after reset: empty message, stray byte without byte_valid.
    '{8'hFF, 1'b0, 1'b1, 1'b1, EmptyDigest},
    // "abc" with the last marker riding on the final byte.
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    // Extreme byte values mixed with ignored bytes.
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b1, 1'b1, 1'b0, '0},
    // A message closed by a last marker that carries no byte.
    '{8'hC3, 1'b1, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b1, 1'b0, '0},
    // Empty message again, zero data.
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    // "abc" followed by a separate byte-less last marker.
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b1, 1'b1, AbcDigest}
  };

  // Clock, reset and block ports; every input starts at a known value.
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;   // [7:0] msg_byte
  logic         s_axis_tuser_i = 1'b0; // [0] byte_valid
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [159:0] m_axis_tdata_o;        // digest_w0, digest_w1, ..., digest_w4

  // Handshake mix and the long output hold-off request.
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 73;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Predictor state: chaining words, block buffer and message length in bytes.
  logic [31:0] hash_chain [5];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_bytes;

  // Pending digests and run statistics.
  logic [159:0] expected_digests [$];
  int unsigned  items_sent = 0;
  int unsigned  messages_sent = 0;
  int unsigned  digests_checked = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  quiet_cycles = 0;

  sha1_message_digest_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  // Print one line per mismatch, up to a cap, and count all of them.
  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MaxPrinted) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic void restart_chain();
    hash_chain[0] = InitChain.a;
    hash_chain[1] = InitChain.b;
    hash_chain[2] = InitChain.c;
    hash_chain[3] = InitChain.d;
    hash_chain[4] = InitChain.e;
    msg_bytes = '0;
  endfunction

  // Eighty rounds over the current block, folded into the chaining words.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < NumRounds; r++) begin
      // The schedule is kept as a 16-word window, updated in place.
      if (r >= 16) begin
        x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
        w[r & 15] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  // Take one accepted input transfer; returns 1 with the digest when a message ends.
  function automatic bit absorb_byte(input logic [7:0] data, input logic byte_valid,
                                     input logic last, output logic [159:0] digest);
    logic [63:0] bit_len;
    int unsigned pos;
    digest = '0;
    if (byte_valid) begin
      block_bytes[msg_bytes[5:0]] = data;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) begin
        compress_block();
      end
    end
    if (!last) begin
      return 1'b0;
    end
    // Padding marker, zero fill, and the big-endian bit length.
    pos = msg_bytes[5:0];
    block_bytes[pos] = PadByte;
    for (int i = pos + 1; i < 64; i++) begin
      block_bytes[i] = 8'h00;
    end
    if (pos >= LenStartPos) begin
      compress_block();
      for (int i = 0; i < LenStartPos; i++) begin
        block_bytes[i] = 8'h00;
      end
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) begin
      block_bytes[LenStartPos + i] = bit_len[8*(7-i) +: 8];
    end
    compress_block();
    digest = {hash_chain[4], hash_chain[3], hash_chain[2], hash_chain[1], hash_chain[0]};
    restart_chain();
    return 1'b1;
  endfunction

  // Offer one transfer after random idle cycles and wait until it is taken.
  task automatic send_item(input logic [7:0] data, input logic byte_valid, input logic last,
                           input logic has_digest, input logic [159:0] fixed_digest);
    logic [159:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= byte_valid;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (absorb_byte(data, byte_valid, last, predicted)) begin
      expected_digests.push_back(has_digest ? fixed_digest : predicted);
    end
    if (byte_valid || last) begin
      items_sent++;
    end
  endtask

  // One random message, sprinkled with ignored bytes, ended on a byte or on its own.
  task automatic send_message(input int unsigned n_bytes);
    logic        end_on_byte;
    int unsigned pick;
    logic [7:0]  data;
    end_on_byte = (n_bytes != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 8) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
      end
      pick = $urandom_range(9);
      data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
      send_item(data, 1'b1, end_on_byte && (i == n_bytes - 1), 1'b0, '0);
    end
    if (!end_on_byte) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
    end
    messages_sent++;
  endtask

  // Stop offering and wait until every pending digest has come out.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_digests.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done       <= 1'b1;
      hold_left       <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Digest checker and watchdog on transfers of either side.
  always @(posedge clk_i) begin : digest_check
    logic [159:0] want;
    logic         in_fire;
    logic         out_fire;
    in_fire  = s_axis_tvalid_i && s_axis_tready_o;
    out_fire = m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni && out_fire) begin
      if (expected_digests.size() == 0) begin
        report_mismatch($sformatf("digest %h with none pending", m_axis_tdata_o));
      end else begin
        want = expected_digests.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (m_axis_tdata_o[32*i +: 32] !== want[32*i +: 32]) begin
            report_mismatch($sformatf("digest_w%0d got %h, expected %h", i,
                                      m_axis_tdata_o[32*i +: 32], want[32*i +: 32]));
          end
        end
        digests_checked++;
      end
    end
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d digests pending",
               quiet_cycles, expected_digests.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus: reset, directed rows, then three phases of random messages.
  initial begin : stimulus
    int unsigned pick;
    int unsigned n_bytes;
    int unsigned phase_end;
    int unsigned boundary [8];
    boundary = '{55, 56, 57, 63, 64, 65, 119, 120};
    for (int i = 0; i < 64; i++) begin
      block_bytes[i] = 8'h00;
    end
    restart_chain();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_item(DirectedRows[i].msg_byte, DirectedRows[i].byte_valid, DirectedRows[i].last,
                DirectedRows[i].has_digest, DirectedRows[i].digest);
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      // Sender light and receiver heavy, then swapped, then no idling with a long hold.
      send_idle_pct <= (phase == 0) ? 10 : (phase == 1) ? 73 : 0;
      recv_idle_pct <= (phase == 0) ? 73 : (phase == 1) ? 10 : 0;
      if (phase == 2) begin
        hold_req <= 1'b1;
      end
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end || (phase == 2 && messages_sent < MinMessages)) begin
        // Mostly short messages, some on the block and padding boundaries.
        pick = $urandom_range(99);
        if (pick < 70) begin
          n_bytes = $urandom_range(8);
        end else if (pick < 85) begin
          n_bytes = boundary[$urandom_range(7)];
        end else begin
          n_bytes = $urandom_range(100);
        end
        send_message(n_bytes);
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (expected_digests.size() != 0) begin
      report_mismatch($sformatf("%0d digests never arrived", expected_digests.size()));
    end
    $display("Sent %0d message items in %0d random messages; checked %0d digests.",
             items_sent, messages_sent, digests_checked);
    $display("Covered empty messages, block and padding boundaries, mixed stalls, long hold-off.");
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
